>>> src/imuas_pkg.sv
// imuas_pkg: shared types, constants and helper functions for the imu auto-range scaler
// no dependencies; imported by every module under src

package imuas_pkg;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned MAG_W   = RAW_W + 1;
    localparam int unsigned ACCEL_W = 25;
    localparam int unsigned GYRO_W  = 28;
    localparam int unsigned TEMP_W  = 24;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned BIAS_W  = 28;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 192;

    // hysteresis thresholds on the largest axis magnitude
    localparam logic [MAG_W-1:0] UP_LIMIT   = 17'd32757;
    localparam logic [MAG_W-1:0] DOWN_LIMIT = 17'd16283;

    localparam logic [CODE_W-1:0] CODE_MIN = 2'd0;
    localparam logic [CODE_W-1:0] CODE_MAX = 2'd3;

    // standard gravity in 2^-16 m/s2
    localparam logic signed [20:0] G_Q16      = 21'sd642689;
    localparam logic signed [10:0] GYRO_LSB   = 11'sd500;
    localparam logic signed [TEMP_W-1:0] TEMP_GAIN = 24'sd125;
    localparam logic signed [TEMP_W-1:0] TEMP_OFS  = 24'sd1474560;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_X = 2'd0,
        REG_BIAS_Y = 2'd1,
        REG_BIAS_Z = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] gyro_z;
        logic signed [RAW_W-1:0] temp;
    } t_sample;

    typedef struct packed {
        logic [CODE_W-1:0] accel_code;
        logic [CODE_W-1:0] gyro_code;
        logic              accel_changed;
        logic              gyro_changed;
    } t_codes;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [GYRO_W-1:0]  gyro_x;
        logic signed [GYRO_W-1:0]  gyro_y;
        logic signed [GYRO_W-1:0]  gyro_z;
        logic signed [TEMP_W-1:0]  temp;
    } t_scaled;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [RAW_W-1:0] raw);
        logic [MAG_W-1:0] ext;
        ext = {raw[RAW_W-1], raw};
        return raw[RAW_W-1] ? (~ext + 17'd1) : ext;
    endfunction

    function automatic logic [MAG_W-1:0] f_peak3(input logic [MAG_W-1:0] a,
                                                  input logic [MAG_W-1:0] b,
                                                  input logic [MAG_W-1:0] c);
        logic [MAG_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [CODE_W-1:0] f_next_code(input logic [CODE_W-1:0] code,
                                                       input logic [MAG_W-1:0]  peak);
        logic [CODE_W-1:0] n;
        n = code;
        priority if (peak >= UP_LIMIT) begin
            if (code != CODE_MAX) n = code + 2'd1;
        end else if (peak < DOWN_LIMIT) begin
            if (code != CODE_MIN) n = code - 2'd1;
        end else begin
            n = code;
        end
        return n;
    endfunction

endpackage

>>> src/imuas_range.sv
// imuas_range: per-sensor full-scale code registers with hysteresis stepping
// depends on imuas_pkg

module imuas_range (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  imuas_pkg::t_sample i_sample,
    output logic [1:0]         o_accel_scale,
    output logic [1:0]         o_gyro_scale,
    output imuas_pkg::t_codes  o_codes
);
    import imuas_pkg::*;

    logic [CODE_W-1:0] r_accel_scale;
    logic [CODE_W-1:0] r_gyro_scale;
    logic [CODE_W-1:0] n_accel_scale;
    logic [CODE_W-1:0] n_gyro_scale;
    logic [MAG_W-1:0]  accel_peak;
    logic [MAG_W-1:0]  gyro_peak;

    always_comb begin
        accel_peak = f_peak3(f_mag(i_sample.accel_x), f_mag(i_sample.accel_y),
                             f_mag(i_sample.accel_z));
        gyro_peak  = f_peak3(f_mag(i_sample.gyro_x), f_mag(i_sample.gyro_y),
                             f_mag(i_sample.gyro_z));
        n_accel_scale = f_next_code(r_accel_scale, accel_peak);
        n_gyro_scale  = f_next_code(r_gyro_scale, gyro_peak);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_scale <= CODE_MIN;
            r_gyro_scale  <= CODE_MIN;
        end else if (i_step) begin
            r_accel_scale <= n_accel_scale;
            r_gyro_scale  <= n_gyro_scale;
        end
    end

    assign o_accel_scale         = r_accel_scale;
    assign o_gyro_scale          = r_gyro_scale;
    assign o_codes.accel_code    = n_accel_scale;
    assign o_codes.gyro_code     = n_gyro_scale;
    assign o_codes.accel_changed = (n_accel_scale != r_accel_scale);
    assign o_codes.gyro_changed  = (n_gyro_scale != r_gyro_scale);

endmodule

>>> src/imuas_scale.sv
// imuas_scale: combinational fixed-point scaling of one raw sample
// depends on imuas_pkg

module imuas_scale (
    input  imuas_pkg::t_sample    i_sample,
    input  logic [1:0]            i_accel_scale,
    input  logic [1:0]            i_gyro_scale,
    input  logic signed [27:0]    i_bias_x,
    input  logic signed [27:0]    i_bias_y,
    input  logic signed [27:0]    i_bias_z,
    output imuas_pkg::t_scaled    o_scaled
);
    import imuas_pkg::*;

    localparam int unsigned PROD_W = RAW_W + 21;

    // raw * g * 2^(code+2) / 2^16, round half up
    function automatic logic signed [ACCEL_W-1:0] f_accel(
        input logic signed [RAW_W-1:0] raw,
        input logic [CODE_W-1:0]       code);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] rnd;
        logic signed [PROD_W-1:0] shr;
        logic [3:0]               sh;
        prod = raw * G_Q16;
        sh   = 4'd14 - {2'b00, code};
        rnd  = prod + (37'sd1 <<< (sh - 4'd1));
        shr  = rnd >>> sh;
        return shr[ACCEL_W-1:0];
    endfunction

    // raw * (500 << code) - bias, saturated to the output width
    function automatic logic signed [GYRO_W-1:0] f_gyro(
        input logic signed [RAW_W-1:0]  raw,
        input logic [CODE_W-1:0]        code,
        input logic signed [BIAS_W-1:0] bias);
        logic signed [25:0]       prod;
        logic signed [GYRO_W-1:0] rate;
        logic signed [GYRO_W:0]   diff;
        logic signed [GYRO_W-1:0] res;
        prod = raw * GYRO_LSB;
        rate = GYRO_W'(prod) <<< code;
        diff = {rate[GYRO_W-1], rate} - {bias[BIAS_W-1], bias};
        if (diff[GYRO_W] != diff[GYRO_W-1]) begin
            res = diff[GYRO_W] ? {1'b1, {(GYRO_W-1){1'b0}}} : {1'b0, {(GYRO_W-1){1'b1}}};
        end else begin
            res = diff[GYRO_W-1:0];
        end
        return res;
    endfunction

    logic signed [TEMP_W-1:0] temp_prod;

    always_comb begin
        temp_prod        = i_sample.temp * TEMP_GAIN;
        o_scaled.accel_x = f_accel(i_sample.accel_x, i_accel_scale);
        o_scaled.accel_y = f_accel(i_sample.accel_y, i_accel_scale);
        o_scaled.accel_z = f_accel(i_sample.accel_z, i_accel_scale);
        o_scaled.gyro_x  = f_gyro(i_sample.gyro_x, i_gyro_scale, i_bias_x);
        o_scaled.gyro_y  = f_gyro(i_sample.gyro_y, i_gyro_scale, i_bias_y);
        o_scaled.gyro_z  = f_gyro(i_sample.gyro_z, i_gyro_scale, i_bias_z);
        o_scaled.temp    = temp_prod + TEMP_OFS;
    end

endmodule

>>> src/imu_autorange_scaler.sv
// imu_autorange_scaler: top level, stream handshake, sample and result registers, bias registers
// depends on imuas_pkg, imuas_range, imuas_scale

// Takes one raw IMU sample per transfer and returns one scaled result per sample, one sample
// per clock when the output side keeps up. The sample is captured in an input register, then
// scaled, range-stepped and captured in the output register. The rate is set by the range
// code registers, which are read and updated in the same cycle as that output capture, so each
// sample sees the codes left by the one before and is scaled with them; the reported codes are
// those for the next sample, with
// a changed flag when a code stepped. Gyro bias registers are written through the config channel
// (index 0..2 = x, y, z; other indexes are ignored) and must only change while the block is idle.

module imu_autorange_scaler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // accel x, y, z, gyro x, y, z, temp: 16 bits each, from bit 0 up
    input  logic [111:0]  i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // accel x, y, z (25 each), gyro x, y, z (28 each), temp (24), accel code (2),
    // gyro code (2), accel changed, gyro changed, 3 zero bits; from bit 0 up
    output logic [191:0]  o_m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [27:0]   i_cfg_data
);
    import imuas_pkg::*;

    logic                     r_in_valid;
    t_sample                  r_sample;
    logic                     r_out_valid;
    t_scaled                  r_scaled;
    t_codes                   r_codes;
    logic signed [BIAS_W-1:0] r_bias_x;
    logic signed [BIAS_W-1:0] r_bias_y;
    logic signed [BIAS_W-1:0] r_bias_z;

    t_sample                  in_sample;
    t_scaled                  n_scaled;
    t_codes                   n_codes;
    logic [CODE_W-1:0]        accel_scale;
    logic [CODE_W-1:0]        gyro_scale;
    logic                     advance;
    logic                     s_accept;
    logic                     step;

    assign in_sample.accel_x = i_s_axis_tdata[15:0];
    assign in_sample.accel_y = i_s_axis_tdata[31:16];
    assign in_sample.accel_z = i_s_axis_tdata[47:32];
    assign in_sample.gyro_x  = i_s_axis_tdata[63:48];
    assign in_sample.gyro_y  = i_s_axis_tdata[79:64];
    assign in_sample.gyro_z  = i_s_axis_tdata[95:80];
    assign in_sample.temp    = i_s_axis_tdata[111:96];

    // output register frees up when empty or its transfer completes
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign step            = advance && r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (advance) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) r_sample <= in_sample;
        if (step) begin
            r_scaled <= n_scaled;
            r_codes  <= n_codes;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= '0;
            r_bias_y <= '0;
            r_bias_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIAS_X: r_bias_x <= i_cfg_data;
                REG_BIAS_Y: r_bias_y <= i_cfg_data;
                REG_BIAS_Z: r_bias_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imuas_range u_range (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_sample      (r_sample),
        .o_accel_scale (accel_scale),
        .o_gyro_scale  (gyro_scale),
        .o_codes       (n_codes)
    );

    imuas_scale u_scale (
        .i_sample      (r_sample),
        .i_accel_scale (accel_scale),
        .i_gyro_scale  (gyro_scale),
        .i_bias_x      (r_bias_x),
        .i_bias_y      (r_bias_y),
        .i_bias_z      (r_bias_z),
        .o_scaled      (n_scaled)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000,
                              r_codes.gyro_changed,
                              r_codes.accel_changed,
                              r_codes.gyro_code,
                              r_codes.accel_code,
                              r_scaled.temp,
                              r_scaled.gyro_z,
                              r_scaled.gyro_y,
                              r_scaled.gyro_x,
                              r_scaled.accel_z,
                              r_scaled.accel_y,
                              r_scaled.accel_x};

endmodule
